@@ rtl/smm_pkg.sv @@
// Package for the small matrix multiply block: widths, codes, the sequencer
// state type, the multiply-accumulate control struct and helper functions.
// No dependencies; every other file of the block uses it.
`default_nettype none

package smm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int DOT_W      = 35;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // Control that travels along the multiply-accumulate pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic lastk;
    } mac_ctl_t;

    // Sizes are saturated into the range 1 to MAX_DIM when written.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_MAX)
            r = DIM_MAX;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_DIM + int'(col));
    endfunction

endpackage

`default_nettype wire

@@ rtl/smm_if.sv @@
// Valid/ready channel interfaces of the small matrix multiply block:
// the input item channel and the result item channel. Uses smm_pkg.
`default_nettype none

interface smm_in_if;
    logic                                valid;
    logic                                ready;
    logic [smm_pkg::FUNC_W-1:0]          func;
    logic [smm_pkg::IDX_W-1:0]           elem_row;
    logic [smm_pkg::IDX_W-1:0]           elem_col;
    logic signed [smm_pkg::ELEM_W-1:0]   element_value;

    modport source (output valid, func, elem_row, elem_col, element_value, input ready);
    modport sink   (input valid, func, elem_row, elem_col, element_value, output ready);
endinterface

interface smm_out_if;
    logic                                valid;
    logic                                ready;
    logic [smm_pkg::IDX_W-1:0]           out_row;
    logic [smm_pkg::IDX_W-1:0]           out_col;
    logic signed [smm_pkg::DOT_W-1:0]    dot_value;
    logic                                last;

    modport source (output valid, out_row, out_col, dot_value, last, input ready);
    modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

`default_nettype wire

@@ rtl/smm_store.sv @@
// Element stores for matrices A and B, one write port and one registered
// read port each. Depends on smm_pkg.
`default_nettype none

module smm_store (
    input  wire logic                               clk,
    input  wire logic                               we_a,
    input  wire logic                               we_b,
    input  wire logic [smm_pkg::ADDR_W-1:0]         waddr,
    input  wire logic signed [smm_pkg::ELEM_W-1:0]  wdata,
    input  wire logic [smm_pkg::ADDR_W-1:0]         ra_addr,
    input  wire logic [smm_pkg::ADDR_W-1:0]         rb_addr,
    output logic signed [smm_pkg::ELEM_W-1:0]       a_q,
    output logic signed [smm_pkg::ELEM_W-1:0]       b_q
);

    logic [smm_pkg::ELEM_W-1:0] a_mem [smm_pkg::DEPTH];
    logic [smm_pkg::ELEM_W-1:0] b_mem [smm_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            a_mem[waddr] <= wdata;
        end
        a_q <= a_mem[ra_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            b_mem[waddr] <= wdata;
        end
        b_q <= b_mem[rb_addr];
    end

endmodule

`default_nettype wire

@@ rtl/smm_mac.sv @@
// Shared multiply-accumulate unit: a registered 16x16 signed product
// followed by a 35-bit accumulator. Depends on smm_pkg.
`default_nettype none

module smm_mac (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire smm_pkg::mac_ctl_t                  issue_ctl,
    input  wire logic signed [smm_pkg::ELEM_W-1:0]  a_q,
    input  wire logic signed [smm_pkg::ELEM_W-1:0]  b_q,
    output logic signed [smm_pkg::DOT_W-1:0]        dot,
    output logic                                    done
);

    smm_pkg::mac_ctl_t                   ctl1_reg;
    smm_pkg::mac_ctl_t                   ctl2_reg;
    logic signed [smm_pkg::PROD_W-1:0]   prod_reg;
    logic signed [smm_pkg::DOT_W-1:0]    acc_reg;
    logic signed [smm_pkg::DOT_W-1:0]    acc_next;
    logic signed [smm_pkg::DOT_W-1:0]    prod_ext;
    logic                                done_reg;

    // The first stage lines the control up with the registered store read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= issue_ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.lastk;
        end
    end

    assign prod_ext = {{(smm_pkg::DOT_W - smm_pkg::PROD_W){prod_reg[smm_pkg::PROD_W-1]}},
                       prod_reg};

    always_comb
    begin
        if (ctl2_reg.first)
            acc_next = prod_ext;
        else
            acc_next = acc_reg + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q * b_q;
        if (ctl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign dot  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/smm_ctrl.sv @@
// Sequencer of the small matrix multiply block: size registers, element
// writes, the row/column/inner loop over the shared unit and the result
// register. Depends on smm_pkg and the channel interfaces in smm_if.sv.
`default_nettype none

module smm_ctrl (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    smm_in_if.sink                                     in_ch,
    smm_out_if.source                                  out_ch,
    input  wire logic                                  cfg_we,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                       we_a,
    output logic                                       we_b,
    output logic [smm_pkg::ADDR_W-1:0]                 waddr,
    output logic [smm_pkg::ADDR_W-1:0]                 ra_addr,
    output logic [smm_pkg::ADDR_W-1:0]                 rb_addr,
    output smm_pkg::mac_ctl_t                          issue_ctl,
    input  wire logic signed [smm_pkg::DOT_W-1:0]      mac_dot,
    input  wire logic                                  mac_done
);

    smm_pkg::state_t                  state_reg, state_next;
    logic [smm_pkg::DIM_W-1:0]        rows_m_reg, inner_k_reg, cols_n_reg;
    logic [smm_pkg::IDX_W-1:0]        i_reg, i_next;
    logic [smm_pkg::IDX_W-1:0]        j_reg, j_next;
    logic [smm_pkg::IDX_W-1:0]        k_reg, k_next;
    logic                             done_seen_reg, done_seen_next;
    logic                             out_valid_reg, out_valid_next;
    logic [smm_pkg::IDX_W-1:0]        out_row_reg, out_col_reg;
    logic signed [smm_pkg::DOT_W-1:0] out_dot_reg;
    logic                             out_last_reg;

    logic accept;
    logic wr_in_range;
    logic i_last, j_last, k_last, res_last;
    logic out_load;

    assign accept      = in_ch.valid && in_ch.ready;
    assign wr_in_range = ({1'b0, in_ch.elem_row} < smm_pkg::DIM_MAX)
                      && ({1'b0, in_ch.elem_col} < smm_pkg::DIM_MAX);
    assign i_last      = ({1'b0, i_reg} + smm_pkg::DIM_W'(1)) == rows_m_reg;
    assign j_last      = ({1'b0, j_reg} + smm_pkg::DIM_W'(1)) == cols_n_reg;
    assign k_last      = ({1'b0, k_reg} + smm_pkg::DIM_W'(1)) == inner_k_reg;
    assign res_last    = i_last && j_last;
    assign out_load    = (state_reg == smm_pkg::ST_DRAIN) && (done_seen_reg || mac_done)
                      && (!out_valid_reg || out_ch.ready);

    assign waddr   = smm_pkg::elem_addr(in_ch.elem_row, in_ch.elem_col);
    assign ra_addr = smm_pkg::elem_addr(i_reg, k_reg);
    assign rb_addr = smm_pkg::elem_addr(k_reg, j_reg);

    // Size registers, saturated on write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= smm_pkg::DIM_MAX;
            inner_k_reg <= smm_pkg::DIM_MAX;
            cols_n_reg  <= smm_pkg::DIM_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smm_pkg::REG_ROWS_M:  rows_m_reg  <= smm_pkg::clamp_dim(cfg_data);
                smm_pkg::REG_INNER_K: inner_k_reg <= smm_pkg::clamp_dim(cfg_data);
                smm_pkg::REG_COLS_N:  cols_n_reg  <= smm_pkg::clamp_dim(cfg_data);
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smm_pkg::ST_IDLE:
            begin
                if (accept && (in_ch.func == smm_pkg::FUNC_COMPUTE))
                    state_next = smm_pkg::ST_ISSUE;
            end
            smm_pkg::ST_ISSUE:
            begin
                if (k_last)
                    state_next = smm_pkg::ST_DRAIN;
            end
            smm_pkg::ST_DRAIN:
            begin
                if (out_load)
                    state_next = res_last ? smm_pkg::ST_IDLE : smm_pkg::ST_ISSUE;
            end
            default: state_next = smm_pkg::ST_IDLE;
        endcase
    end

    // Outputs and counter updates.
    always_comb
    begin
        in_ch.ready     = 1'b0;
        we_a            = 1'b0;
        we_b            = 1'b0;
        issue_ctl       = '0;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        case (state_reg)
            smm_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                we_a = accept && wr_in_range && (in_ch.func == smm_pkg::FUNC_WR_A);
                we_b = accept && wr_in_range && (in_ch.func == smm_pkg::FUNC_WR_B);
            end
            smm_pkg::ST_ISSUE:
            begin
                issue_ctl.valid = 1'b1;
                issue_ctl.first = (k_reg == '0);
                issue_ctl.lastk = k_last;
                k_next = k_last ? '0 : k_reg + smm_pkg::IDX_W'(1);
            end
            smm_pkg::ST_DRAIN:
            begin
                if (out_load)
                begin
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_last ? '0 : i_reg + smm_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + smm_pkg::IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign done_seen_next = out_load ? 1'b0 : (done_seen_reg || mac_done);
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smm_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            done_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            done_seen_reg <= done_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_dot_reg  <= mac_dot;
            out_last_reg <= res_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_row   = out_row_reg;
    assign out_ch.out_col   = out_col_reg;
    assign out_ch.dot_value = out_dot_reg;
    assign out_ch.last      = out_last_reg;

    // The loop counters never leave the configured sizes.
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, i_reg} < rows_m_reg) && ({1'b0, j_reg} < cols_n_reg)
        && ({1'b0, k_reg} < inner_k_reg))
        else $error("loop counter beyond configured size");

    // A finished dot product only arrives while the sequencer waits for it.
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == smm_pkg::ST_DRAIN))
        else $error("accumulator finished outside the drain phase");

    // The result flagged last ends the run.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_last) |=> (state_reg == smm_pkg::ST_IDLE) && out_ch.last)
        else $error("run did not end after its last result");

    // Nothing enters the pipeline while input items are taken.
    a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !issue_ctl.valid && !mac_done)
        else $error("pipeline busy while taking input items");

endmodule

`default_nettype wire

@@ rtl/small_matrix_multiply_top.sv @@
// Top level of the small matrix multiply block, C = A x B in Q8.8 / Q19.16.
// Write items are taken while the sequencer idles. A compute item keeps ready low until its
// last result is loaded: per result, one issue per inner index on the single multiply-
// accumulate unit, then store read, product, accumulator, result registers and receiver stall.
// rst_n is asynchronous, active low: sizes return to 8, the sequencer idles, stores keep data.
// Depends on smm_pkg, smm_if.sv, smm_store, smm_mac and smm_ctrl.
`default_nettype none

module small_matrix_multiply_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    smm_in_if.sink                                in_ch,
    smm_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                               we_a;
    logic                               we_b;
    logic [smm_pkg::ADDR_W-1:0]         waddr;
    logic [smm_pkg::ADDR_W-1:0]         ra_addr;
    logic [smm_pkg::ADDR_W-1:0]         rb_addr;
    logic signed [smm_pkg::ELEM_W-1:0]  a_q;
    logic signed [smm_pkg::ELEM_W-1:0]  b_q;
    smm_pkg::mac_ctl_t                  issue_ctl;
    logic signed [smm_pkg::DOT_W-1:0]   mac_dot;
    logic                               mac_done;

    // The sequencer walks the result in row-major order. For each result it issues
    // one store read per inner index; the matching products are summed, and once the
    // sum is complete it moves into the result register, which frees the accumulator
    // for the next result while the item waits to be taken.
    smm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .we_a      (we_a),
        .we_b      (we_b),
        .waddr     (waddr),
        .ra_addr   (ra_addr),
        .rb_addr   (rb_addr),
        .issue_ctl (issue_ctl),
        .mac_dot   (mac_dot),
        .mac_done  (mac_done)
    );

    // Element values are written straight from the input item.
    smm_store u_store (
        .clk     (clk),
        .we_a    (we_a),
        .we_b    (we_b),
        .waddr   (waddr),
        .wdata   (in_ch.element_value),
        .ra_addr (ra_addr),
        .rb_addr (rb_addr),
        .a_q     (a_q),
        .b_q     (b_q)
    );

    smm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_ctl (issue_ctl),
        .a_q       (a_q),
        .b_q       (b_q),
        .dot       (mac_dot),
        .done      (mac_done)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for small_matrix_multiply_top: loads Q8.8 elements of A and B,
// issues compute items and checks every Q19.16 result item against an internal predictor.
// Depends on smm_pkg, smm_if.sv (smm_in_if, smm_out_if) and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    import smm_pkg::*;

    // Selector value that the block does not decode, and the one register index that
    // lies beyond the three size registers. Both must be ignored by the block.
    localparam logic [FUNC_W-1:0]    FUNC_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // After the last result of a compute item the sequencer returns to idle as that result
    // is loaded into the result register. Config writes wait this long after draining.
    localparam int SETTLE_CYCLES   = 16;
    // Guard against a hung run. This limit is many times what the slowest correct run can
    // need, with full 8x8x8 computes and receiver stalls included.
    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int MAX_REPORTS     = 10;

    // One input item as the driver puts it on the channel.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } mm_op_t;

    // One result item as the block should deliver it.
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } dot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smm_in_if  in_ch ();
    smm_out_if out_ch ();

    small_matrix_multiply_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Items waiting to be driven, filled ahead of time by the stimulus process.
    mm_op_t op_queue[$];
    // Result items predicted but not yet seen on the output channel, oldest first.
    dot_t   pending_dots[$];

    // Predictor state: images of both element stores and the sizes in effect.
    logic signed [ELEM_W-1:0] a_img [DEPTH];
    logic signed [ELEM_W-1:0] b_img [DEPTH];
    logic [DIM_W-1:0] cur_m = DIM_W'(8);
    logic [DIM_W-1:0] cur_k = DIM_W'(8);
    logic [DIM_W-1:0] cur_n = DIM_W'(8);

    // The stores are undefined until written, so the stimulus remembers which entries it
    // has loaded and never lets a compute item read any other entry.
    bit a_seen [DEPTH];
    bit b_seen [DEPTH];

    int  queued_items   = 0;
    int  accepted_items = 0;
    int  useful_items   = 0;
    int  bad_count      = 0;
    int  cycle_count    = 0;
    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    bit  in_taken       = 1'b0;
    mm_op_t drive_op;
    dot_t   want;

    // Sizes saturate at write time: zero counts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] raw);
        if (raw == '0)
            return DIM_W'(1);
        if (int'(raw) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        return raw;
    endfunction

    // Element values lean toward the corners of the Q8.8 range.
    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return -16'sd1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Mostly small sizes keep compute items short; now and then a raw value above the
    // range, which the block must saturate to MAX_DIM.
    function automatic logic [DIM_W-1:0] rand_dim();
        if ($urandom_range(9) == 0)
            return DIM_W'($urandom_range(15, 9));
        return DIM_W'($urandom_range(4));
    endfunction

    // Predictor: applies one accepted item to the store images and, for a compute item,
    // appends every dot product in row-major order to the expected results.
    task automatic track_item(input mm_op_t op);
        logic signed [DOT_W-1:0] acc;
        dot_t res;
        case (op.func)
            FUNC_WR_A: a_img[{op.row, op.col}] = op.value;
            FUNC_WR_B: b_img[{op.row, op.col}] = op.value;
            FUNC_COMPUTE:
            begin
                for (int i = 0; i < int'(cur_m); i++)
                begin
                    for (int j = 0; j < int'(cur_n); j++)
                    begin
                        acc = '0;
                        for (int kk = 0; kk < int'(cur_k); kk++)
                        begin
                            acc = acc + a_img[{IDX_W'(i), IDX_W'(kk)}]
                                      * b_img[{IDX_W'(kk), IDX_W'(j)}];
                        end
                        res.row  = IDX_W'(i);
                        res.col  = IDX_W'(j);
                        res.dot  = acc;
                        res.last = (i == int'(cur_m) - 1) && (j == int'(cur_n) - 1);
                        pending_dots.insert(pending_dots.size(), res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Input side and output side, both sampled at the rising edge. An accepted input item
    // goes through the predictor; an accepted result item is checked against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_taken = 1'b1;
                accepted_items++;
                track_item('{in_ch.func, in_ch.elem_row, in_ch.elem_col, in_ch.element_value});
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_dots.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("unexpected result item: row %0d col %0d dot %0d last %0b",
                                 out_ch.out_row, out_ch.out_col, out_ch.dot_value,
                                 out_ch.last);
                end
                else
                begin
                    want = pending_dots.pop_front();
                    if (out_ch.out_row !== want.row || out_ch.out_col !== want.col ||
                        out_ch.dot_value !== want.dot || out_ch.last !== want.last)
                    begin
                        bad_count++;
                        if (bad_count <= MAX_REPORTS)
                            $display({"result mismatch at cycle %0d: expected row %0d col %0d ",
                                      "dot %0d last %0b, got row %0d col %0d dot %0d last %0b"},
                                     cycle_count, want.row, want.col, want.dot, want.last,
                                     out_ch.out_row, out_ch.out_col, out_ch.dot_value,
                                     out_ch.last);
                    end
                end
            end
        end
    end

    // Driver, at the falling edge. A new item is offered only once the previous one was
    // taken, so the payload holds steady while valid waits for ready. The sender gap and
    // the receiver stall are drawn independently each cycle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (op_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    drive_op = op_queue.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.func          <= drive_op.func;
                    in_ch.elem_row      <= drive_op.row;
                    in_ch.elem_col      <= drive_op.col;
                    in_ch.element_value <= drive_op.value;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake or a result that never comes ends the run here.
    initial
    begin
        while (cycle_count < WATCHDOG_CYCLES)
            @(negedge clk);
        $display("[small_matrix_multiply_top] ERROR");
        $finish;
    end

    // Appends one item to the stimulus and records which store entries are now defined.
    task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] value);
        mm_op_t op;
        op = '{func, row, col, value};
        op_queue.insert(op_queue.size(), op);
        queued_items++;
        if (func != FUNC_NONE)
            useful_items++;
        if (func == FUNC_WR_A)
            a_seen[{row, col}] = 1'b1;
        if (func == FUNC_WR_B)
            b_seen[{row, col}] = 1'b1;
    endtask

    // A well-formed compute: first load every operand entry that the current sizes read
    // and that was never written (and, on refresh, about half of the others with fresh
    // values), then the compute item itself.
    task automatic queue_compute(input bit refresh);
        for (int r = 0; r < int'(cur_m); r++)
            for (int c = 0; c < int'(cur_k); c++)
                if (!a_seen[{IDX_W'(r), IDX_W'(c)}] || (refresh && $urandom_range(1)))
                    queue_op(FUNC_WR_A, IDX_W'(r), IDX_W'(c), rand_elem());
        for (int r = 0; r < int'(cur_k); r++)
            for (int c = 0; c < int'(cur_n); c++)
                if (!b_seen[{IDX_W'(r), IDX_W'(c)}] || (refresh && $urandom_range(1)))
                    queue_op(FUNC_WR_B, IDX_W'(r), IDX_W'(c), rand_elem());
        queue_op(FUNC_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    endtask

    // Sender pause: hold back until every queued item was taken and every expected result
    // has arrived, then give the sequencer time to settle back to idle.
    task automatic wait_drained();
        while (accepted_items != queued_items || pending_dots.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write, with the enable low before it so that the write enable is never
    // lowered and raised within one time step. The predictor's copy follows at once; the
    // block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_ROWS_M:  cur_m = sat_dim(data);
            REG_INNER_K: cur_k = sat_dim(data);
            REG_COLS_N:  cur_n = sat_dim(data);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sizes(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                             input logic [DIM_W-1:0] n);
        wait_drained();
        write_reg(REG_ROWS_M, m);
        write_reg(REG_INNER_K, k);
        write_reg(REG_COLS_N, n);
    endtask

    // Random traffic for the sizes in effect. Most of it is well-formed load-then-compute
    // sequences with random content; the rest is stray writes anywhere in the stores,
    // items with the unused selector, and back-to-back computes on the stored operands.
    task automatic traffic_burst(input int budget);
        int start;
        int pick;
        start = useful_items;
        while (useful_items - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    if ($urandom_range(1))
                        queue_op(FUNC_WR_A, IDX_W'($urandom_range(int'(cur_m) - 1)),
                                 IDX_W'($urandom_range(int'(cur_k) - 1)), rand_elem());
                    else
                        queue_op(FUNC_WR_B, IDX_W'($urandom_range(int'(cur_k) - 1)),
                                 IDX_W'($urandom_range(int'(cur_n) - 1)), rand_elem());
                end
                queue_compute(1'b0);
            end
            else if (pick < 65)
                queue_compute(1'b1);
            else if (pick < 82)
            begin
                repeat ($urandom_range(3, 1))
                    queue_op($urandom_range(1) ? FUNC_WR_B : FUNC_WR_A, IDX_W'($urandom),
                             IDX_W'($urandom), rand_elem());
            end
            else if (pick < 90)
                queue_op(FUNC_NONE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
            else
                queue_compute(1'b0);
            if ($urandom_range(39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        // Every input is known from time zero, while reset is held.
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_WR_A;
        in_ch.elem_row      = '0;
        in_ch.elem_col      = '0;
        in_ch.element_value = '0;
        out_ch.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_ROWS_M;
        cfg_data            = '0;
        send_gap_pct        = 16;
        recv_stall_pct      = 49;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part. Size writes of zero and of fifteen must saturate to one and to
        // eight, and a write to the index past the size registers must change nothing:
        // the sizes become 1 x 8 x 2.
        write_reg(REG_ROWS_M, DIM_W'(0));
        write_reg(REG_INNER_K, DIM_W'(15));
        write_reg(REG_COLS_N, DIM_W'(2));
        write_reg(REG_UNUSED, DIM_W'(5));

        // Row 0 of A at the most negative element, column 0 of B likewise and column 1 of B
        // at the most positive one: the two dot products are the largest positive sum,
        // exactly 2^33, and the most negative one the block can produce.
        for (int c = 0; c < MAX_DIM; c++)
            queue_op(FUNC_WR_A, IDX_W'(0), IDX_W'(c), 16'sh8000);
        for (int r = 0; r < MAX_DIM; r++)
        begin
            queue_op(FUNC_WR_B, IDX_W'(r), IDX_W'(0), 16'sh8000);
            queue_op(FUNC_WR_B, IDX_W'(r), IDX_W'(1), 16'sh7fff);
        end
        // The unused selector aimed at a loaded entry must not disturb it.
        queue_op(FUNC_NONE, IDX_W'(0), IDX_W'(0), '0);
        queue_op(FUNC_COMPUTE, IDX_W'(7), IDX_W'(7), -16'sd1);

        // Random part in three idling regimes, several size settings each, with the
        // extremes among them. Every change of sizes waits for the block to drain.
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_gap_pct   = 16;
                    recv_stall_pct = 49;
                end
                1:
                begin
                    send_gap_pct   = 49;
                    recv_stall_pct = 16;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int s = 0; s < 3; s++)
            begin
                case (p * 3 + s)
                    0: set_sizes(DIM_W'(1), DIM_W'(1), DIM_W'(1));
                    1: set_sizes(DIM_W'(15), DIM_W'(15), DIM_W'(15));
                    3: set_sizes(DIM_W'(8), DIM_W'(1), DIM_W'(8));
                    4: set_sizes(DIM_W'(1), DIM_W'(8), DIM_W'(1));
                    7: set_sizes(DIM_W'(2), DIM_W'(3), DIM_W'(4));
                    8: set_sizes(DIM_W'(8), DIM_W'(8), DIM_W'(8));
                    default: set_sizes(rand_dim(), rand_dim(), rand_dim());
                endcase
                traffic_burst(12);
            end
        end

        // Wind down: everything taken, every result in, then a quiet stretch in which any
        // surplus result item would be flagged by the checker.
        while (accepted_items != queued_items || pending_dots.size() != 0)
            @(negedge clk);
        repeat (4 * SETTLE_CYCLES) @(negedge clk);

        if (pending_dots.size() != 0)
            $display("%0d expected result items never arrived", pending_dots.size());
        if (bad_count == 0 && pending_dots.size() == 0)
            $display("[small_matrix_multiply_top] OK");
        else
            $display("[small_matrix_multiply_top] ERROR");
        $finish;
    end

endmodule
